[sv/hbd_pkg.sv]
package hbd_pkg;

  // configuration register reset values
  localparam logic [17:0] FINGER_THR_RST = 18'd50000;
  localparam logic [17:0] MIN_AMP_RST    = 18'd200;
  localparam logic [15:0] MIN_IVL_RST    = 16'd300;
  localparam logic [15:0] MAX_IVL_RST    = 16'd2000;
  localparam logic [7:0]  SMP_PERIOD_RST = 8'd40;

  // rate numerator (ms per minute) and interval history reset value
  localparam logic [15:0] BPM_NUM  = 16'd60000;
  localparam logic [15:0] RING_RST = 16'd800;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_FINGER_THR = 3'd0,
    REG_MIN_AMP    = 3'd1,
    REG_MIN_IVL    = 3'd2,
    REG_MAX_IVL    = 3'd3,
    REG_SMP_PERIOD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [17:0] finger_threshold;
    logic [17:0] min_amplitude;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [7:0]  sample_period_ms;
  } cfg_t;

  // what the back end has to do with one sample
  typedef enum logic [1:0] {
    K_NOFINGER = 2'd0,
    K_PLAIN    = 2'd1,
    K_BEAT     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] ms;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_FILT = 2'd1,
    F_MUL  = 2'd2,
    F_PUSH = 2'd3
  } f_state_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_READ   = 3'd1,
    B_UPD    = 3'd2,
    B_AVG    = 3'd3,
    B_AVG_W  = 3'd4,
    B_RATE   = 3'd5,
    B_RATE_W = 3'd6,
    B_OUT    = 3'd7
  } b_state_t;

endpackage

[sv/hbd_front.sv]
module hbd_front
  import hbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [17:0] in_ir_sample,
  output logic        push,
  output q_entry_t    push_entry,
  input  logic        q_full
);

  f_state_t state_r, state_nxt;

  logic [17:0] sample_r;
  logic [19:0] smooth_r, prev_r, peak_r, trough_r;
  logic        rising_r;
  logic [31:0] cnt_r, last_r;
  logic        nofinger_r, cand_r;
  logic [31:0] n_r, ms_r;

  // filter and peak tracking for the held sample
  logic        nofinger;
  logic [19:0] s, pk, tr, peak_nxt, trough_nxt;
  logic        turn, amp_ok, rising_mid, rising_nxt;
  logic [20:0] tr_plus_amp;

  always_comb begin
    nofinger    = sample_r < cfg.finger_threshold;
    s           = smooth_r - (smooth_r >> 2) + {4'b0, sample_r[17:2]};
    pk          = (s > peak_r) ? s : peak_r;
    tr          = (s < trough_r) ? s : trough_r;
    turn        = (s < prev_r) && rising_r;
    tr_plus_amp = {1'b0, tr} + {3'b0, cfg.min_amplitude};
    amp_ok      = {1'b0, pk} > tr_plus_amp;
    trough_nxt  = turn ? s : tr;
    rising_mid  = turn ? 1'b0 : rising_r;
    peak_nxt    = pk;
    rising_nxt  = rising_mid;
    if (s > prev_r) begin
      if (!rising_mid) peak_nxt = s;
      rising_nxt = 1'b1;
    end
  end

  // interval in ms, low 32 bits
  logic [31:0] prod;
  assign prod = n_r * {24'b0, cfg.sample_period_ms};

  logic in_win, too_long;
  assign in_win   = (ms_r > {16'b0, cfg.min_interval_ms}) &&
                    (ms_r < {16'b0, cfg.max_interval_ms});
  assign too_long = ms_r >= {16'b0, cfg.max_interval_ms};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_FILT;
      F_FILT:  state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    push            = 1'b0;
    push_entry.ms   = ms_r[15:0];
    push_entry.kind = nofinger_r ? K_NOFINGER : ((cand_r && in_win) ? K_BEAT : K_PLAIN);
    case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_PUSH:  push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      smooth_r <= '0;
      prev_r   <= '0;
      peak_r   <= '0;
      trough_r <= '0;
      rising_r <= 1'b0;
      cnt_r    <= '0;
      last_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        sample_r <= in_ir_sample;
        cnt_r    <= cnt_r + 32'd1;
      end
      if (state_r == F_FILT) begin
        nofinger_r <= nofinger;
        n_r        <= cnt_r - last_r;
        if (nofinger) begin
          smooth_r <= {2'b0, sample_r};
          prev_r   <= {2'b0, sample_r};
          rising_r <= 1'b0;
          cand_r   <= 1'b0;
        end else begin
          smooth_r <= s;
          prev_r   <= s;
          peak_r   <= peak_nxt;
          trough_r <= trough_nxt;
          rising_r <= rising_nxt;
          cand_r   <= turn && amp_ok;
        end
      end
      if (state_r == F_MUL) ms_r <= prod;
      // a beat or a too-long interval restarts timing
      if (push && cand_r && (in_win || too_long)) last_r <= cnt_r;
    end
  end

endmodule

[sv/hbd_queue.sv]
module hbd_queue
  import hbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t       mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPW:0]   cnt_r;

  assign full  = cnt_r == (QPW+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/hbd_div.sv]
module hbd_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r, quo_r, dvs_r;

  // one restoring step per cycle
  logic [W:0]   trial, diff;
  logic         ge;
  logic [W-1:0] rem_nxt, quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/hbd_back.sv]
module hbd_back
  import hbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_entry_t    head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_beats_per_minute,
  output logic        out_finger_present,
  output logic        out_beat_accepted
);

  localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int TOT_W = 16 + $clog2(HISTORY_DEPTH);
  localparam logic [TOT_W-1:0] TOT_RST = TOT_W'(800 * HISTORY_DEPTH);

  // ring average as total * ceil(2^SH / depth) >> SH, exact for any TOT_W-bit total
  localparam int AVG_SH = TOT_W + $clog2(HISTORY_DEPTH);
  localparam logic [TOT_W:0] AVG_RECIP =
    (TOT_W+1)'(((64'd1 << AVG_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  b_state_t state_r, state_nxt;

  logic [15:0]        ring_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic [15:0]        rd_r;
  logic               rd_vld_r;
  logic [PW-1:0]      pos_r;
  logic [TOT_W-1:0]   total_r;
  logic [15:0]        ms_r, avg_r, rate_r;

  logic        out_valid_r, out_fp_r, out_ba_r;
  logic [15:0] out_bpm_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  logic [2*TOT_W-1:0] avg_prod;
  logic [15:0]        avg_nxt;
  assign avg_prod = (2*TOT_W)'(total_r) * (2*TOT_W)'(AVG_RECIP);
  assign avg_nxt  = 16'(avg_prod >> AVG_SH);

  // serial divider for the rate
  logic        div_start, div_done;
  logic [15:0] div_q;

  hbd_div #(.W(16)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (BPM_NUM),
    .divisor  (avg_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic ld_out, ld_beat, ring_wr, take_avg, take_rate;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (!q_empty && head.kind == K_BEAT) state_nxt = B_READ;
      B_READ:   state_nxt = B_UPD;
      B_UPD:    state_nxt = B_AVG;
      B_AVG:    state_nxt = B_AVG_W;
      B_AVG_W:  state_nxt = (avg_r == '0) ? B_OUT : B_RATE;
      B_RATE:   state_nxt = B_RATE_W;
      B_RATE_W: if (div_done) state_nxt = B_OUT;
      B_OUT:    if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    ld_out    = 1'b0;
    ld_beat   = 1'b0;
    ring_wr   = 1'b0;
    div_start = 1'b0;
    take_avg  = 1'b0;
    take_rate = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.kind == K_BEAT) begin
            pop     = 1'b1;
            ld_beat = 1'b1;
          end else if (out_free) begin
            pop    = 1'b1;
            ld_out = 1'b1;
          end
        end
      end
      B_UPD:    ring_wr = 1'b1;
      B_AVG:    take_avg = 1'b1;
      B_RATE:   div_start = 1'b1;
      B_RATE_W: take_rate = div_done;
      B_OUT:    ld_out = out_free;
      default: ;
    endcase
  end

  // interval history; unwritten entries read as the reset interval
  always_ff @(posedge clk) begin
    if (ring_wr) ring_mem[pos_r] <= ms_r;
    rd_r <= ring_mem[pos_r];
  end

  logic [15:0] old_ms;
  assign old_ms = rd_vld_r ? rd_r : RING_RST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      pos_r       <= '0;
      total_r     <= TOT_RST;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[pos_r];
      if (ld_beat) ms_r <= head.ms;
      if (ring_wr) begin
        vld_r[pos_r] <= 1'b1;
        total_r      <= total_r - TOT_W'(old_ms) + TOT_W'(ms_r);
        pos_r        <= (pos_r == PW'(HISTORY_DEPTH - 1)) ? '0 : pos_r + PW'(1);
      end
      if (take_avg)  avg_r  <= avg_nxt;
      if (take_rate) rate_r <= div_q;
      if (ld_out && state_r == B_IDLE && head.kind == K_NOFINGER) rate_r <= '0;

      // result word register
      if (ld_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (ld_out) begin
        if (state_r == B_OUT) begin
          out_bpm_r <= rate_r;
          out_fp_r  <= 1'b1;
          out_ba_r  <= 1'b1;
        end else if (head.kind == K_NOFINGER) begin
          out_bpm_r <= '0;
          out_fp_r  <= 1'b0;
          out_ba_r  <= 1'b0;
        end else begin
          out_bpm_r <= rate_r;
          out_fp_r  <= 1'b1;
          out_ba_r  <= 1'b0;
        end
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_beats_per_minute = out_bpm_r;
  assign out_finger_present   = out_fp_r;
  assign out_beat_accepted    = out_ba_r;

endmodule

[sv/heart_beat_bpm_detector_core.sv]
// Path: a word without a beat passes filter, multiply, queue push and result register;
//   a beat word adds ring update, reciprocal average and, for a nonzero average, a 16-step
//   serial rate divide. Flow: the front end takes no sample while one is in work, and
//   stalls on a full 4-word queue; the back end pops no word while a beat word is in work.
// Reset: synchronous, active low; registers go to their reset values, history reads 800.
module heart_beat_bpm_detector_core
  import hbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [17:0] in_ir_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_beats_per_minute,
  output logic        out_finger_present,
  output logic        out_beat_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;

  // configuration registers
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.finger_threshold <= FINGER_THR_RST;
      cfg_r.min_amplitude    <= MIN_AMP_RST;
      cfg_r.min_interval_ms  <= MIN_IVL_RST;
      cfg_r.max_interval_ms  <= MAX_IVL_RST;
      cfg_r.sample_period_ms <= SMP_PERIOD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FINGER_THR: cfg_r.finger_threshold <= pwdata[17:0];
        REG_MIN_AMP:    cfg_r.min_amplitude    <= pwdata[17:0];
        REG_MIN_IVL:    cfg_r.min_interval_ms  <= pwdata[15:0];
        REG_MAX_IVL:    cfg_r.max_interval_ms  <= pwdata[15:0];
        REG_SMP_PERIOD: cfg_r.sample_period_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FINGER_THR: prdata = {14'b0, cfg_r.finger_threshold};
      REG_MIN_AMP:    prdata = {14'b0, cfg_r.min_amplitude};
      REG_MIN_IVL:    prdata = {16'b0, cfg_r.min_interval_ms};
      REG_MAX_IVL:    prdata = {16'b0, cfg_r.max_interval_ms};
      REG_SMP_PERIOD: prdata = {24'b0, cfg_r.sample_period_ms};
      default:        prdata = '0;
    endcase
  end

  q_entry_t push_entry, head;
  logic     push, pop, q_full, q_empty;

  hbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ir_sample (in_ir_sample),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  hbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  hbd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_empty              (q_empty),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_beats_per_minute (out_beats_per_minute),
    .out_finger_present   (out_finger_present),
    .out_beat_accepted    (out_beat_accepted)
  );

endmodule

[bench/heart_beat_bpm_detector_core_tb.sv]
module heart_beat_bpm_detector_core_tb;
  import hbd_pkg::*;

  localparam int HIST    = 10;
  localparam int LAT_CYC = 64;   // worst beat word through the divider, with margin
  localparam int IR_MAX  = 262143;

  typedef struct packed {
    logic [15:0] bpm;
    logic        finger;
    logic        beat;
  } reading_t;

  // Heart-rate tracker: mirrors the detector state and queues the readings it predicts
  class rate_checker;
    logic [17:0] thr;
    logic [17:0] amp_min;
    logic [15:0] ivl_min;
    logic [15:0] ivl_max;
    logic [7:0]  per_ms;
    logic [19:0] smooth;
    logic [19:0] prev_smooth;
    logic [19:0] peak;
    logic [19:0] trough;
    bit          rising;
    logic [31:0] n_samples;
    logic [31:0] last_beat;
    logic [15:0] ivl_hist [HIST];
    int unsigned hist_pos;
    logic [15:0] rate;
    reading_t    pending [$];
    int          errors;

    function new();
      thr         = FINGER_THR_RST;
      amp_min     = MIN_AMP_RST;
      ivl_min     = MIN_IVL_RST;
      ivl_max     = MAX_IVL_RST;
      per_ms      = SMP_PERIOD_RST;
      smooth      = '0;
      prev_smooth = '0;
      peak        = '0;
      trough      = '0;
      rising      = 1'b0;
      n_samples   = '0;
      last_beat   = '0;
      for (int k = 0; k < HIST; k++) ivl_hist[k] = RING_RST;
      hist_pos    = 0;
      rate        = '0;
      errors      = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_FINGER_THR: thr     = v[17:0];
        REG_MIN_AMP:    amp_min = v[17:0];
        REG_MIN_IVL:    ivl_min = v[15:0];
        REG_MAX_IVL:    ivl_max = v[15:0];
        REG_SMP_PERIOD: per_ms  = v[7:0];
        default: ;
      endcase
    endfunction

    // predict the reading for one accepted IR word
    function void take_sample(logic [17:0] ir);
      logic [19:0] s;
      logic [31:0] ms;
      logic [31:0] total;
      logic [31:0] avg;
      int          amp;
      bit          beat;
      reading_t    r;
      beat = 1'b0;
      n_samples = n_samples + 32'd1;

      // no finger: clear rate, reload filter
      if (ir < thr) begin
        rate        = '0;
        rising      = 1'b0;
        smooth      = {2'b00, ir};
        prev_smooth = smooth;
        r = '{bpm: 16'd0, finger: 1'b0, beat: 1'b0};
        pending.push_back(r);
        return;
      end

      // quarter-alpha low-pass
      s = smooth - (smooth >> 2) + {4'b0000, ir[17:2]};
      smooth = s;
      if (s > peak) peak = s;
      if (s < trough) trough = s;

      // turn from rising to falling
      if (s < prev_smooth && rising) begin
        amp = int'(peak) - int'(trough);
        if (amp > int'(amp_min)) begin
          ms = (n_samples - last_beat) * {24'd0, per_ms};
          if (ms > {16'd0, ivl_min} && ms < {16'd0, ivl_max}) begin
            ivl_hist[hist_pos] = ms[15:0];
            hist_pos = (hist_pos + 1) % HIST;
            total = '0;
            for (int k = 0; k < HIST; k++) total = total + {16'd0, ivl_hist[k]};
            avg = total / HIST;
            if (avg > 0) rate = 16'({16'd0, BPM_NUM} / avg);
            last_beat = n_samples;
            beat = 1'b1;
          end else if (ms >= {16'd0, ivl_max}) begin
            last_beat = n_samples;
          end
        end
        trough = s;
        rising = 1'b0;
      end

      // rise start reloads the peak
      if (s > prev_smooth) begin
        if (!rising) peak = s;
        rising = 1'b1;
      end
      prev_smooth = s;

      r = '{bpm: rate, finger: 1'b1, beat: beat};
      pending.push_back(r);
    endfunction

    function void check_reading(logic [15:0] bpm, logic finger, logic beat);
      reading_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word bpm %0d finger %0b beat %0b",
                 $time, bpm, finger, beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (bpm !== want.bpm) begin
        $display("%0t: bpm expected %0d, got %0d", $time, want.bpm, bpm);
        errors++;
      end
      if (finger !== want.finger) begin
        $display("%0t: finger_present expected %0b, got %0b", $time, want.finger, finger);
        errors++;
      end
      if (beat !== want.beat) begin
        $display("%0t: beat_accepted expected %0b, got %0b", $time, want.beat, beat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [17:0] in_ir_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_beats_per_minute;
  logic        out_finger_present;
  logic        out_beat_accepted;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rate_checker sb;
  int          burst_left = 0;
  bit          idle_on = 1'b1;
  int          rx_cyc = 0;

  heart_beat_bpm_detector_core #(.HISTORY_DEPTH(HIST)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_ir_sample         (in_ir_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_beats_per_minute (out_beats_per_minute),
    .out_finger_present   (out_finger_present),
    .out_beat_accepted    (out_beat_accepted),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stall pattern: free-flowing, random, sparse periodic ready, long stalls
  always @(negedge clk) begin
    case ((rx_cyc / 97) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ((rx_cyc % 3) == 0);
      default: out_ready <= ((rx_cyc % 16) >= 12);
    endcase
    rx_cyc <= rx_cyc + 1;
  end

  // check results before noting new words so a stray result cannot match them
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_reading(out_beats_per_minute, out_finger_present, out_beat_accepted);
      if (in_valid && in_ready) sb.take_sample(in_ir_sample);
    end
  end

  // one IR word, with bursts and gaps on the sender side
  task automatic send_sample(input logic [17:0] ir);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_ir_sample = ir;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
  endtask

  // triangle pulse train with noise and occasional finger dropouts
  task automatic send_wave(input int base, input int swing, input int per, input int len,
                           input int noise, input bit drop);
    int half;
    int pos;
    int x;
    half = per / 2;
    for (int t = 0; t < len; t++) begin
      pos = t % per;
      x = base + ((pos < half) ? pos * swing / half : (per - pos) * swing / half);
      x = x + $urandom_range(0, noise);
      if (drop && sb.thr > 0 && $urandom_range(0, 49) == 0)
        x = $urandom_range(0, int'(sb.thr) - 1);
      if (x > IR_MAX) x = IR_MAX;
      send_sample(18'(x));
    end
  endtask

  // wait until every expected word is back and the back end is quiet
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // reprogram all registers, then mostly pulse trains plus noise and dropouts
  task automatic run_phase(input int thr, input int amp, input int mn, input int mx,
                           input int per, input int n_items, input bit idle);
    int sent;
    int len;
    int sel;
    int wper;
    drain();
    cfg_write(REG_FINGER_THR, 32'(thr));
    cfg_write(REG_MIN_AMP, 32'(amp));
    cfg_write(REG_MIN_IVL, 32'(mn));
    cfg_write(REG_MAX_IVL, 32'(mx));
    cfg_write(REG_SMP_PERIOD, 32'(per));
    idle_on = idle;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) begin
        len  = $urandom_range(10, 50);
        if (len > n_items - sent) len = n_items - sent;
        wper = $urandom_range(0, 1) ? $urandom_range(2, 12) : $urandom_range(12, 70);
        send_wave(int'(sb.thr) + $urandom_range(0, 60000), $urandom_range(0, 40000),
                  wper, len, $urandom_range(0, 500), 1'b1);
      end else if (sel < 18) begin
        len = $urandom_range(1, 5);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) send_sample(18'($urandom_range(0, IR_MAX)));
      end else begin
        len = $urandom_range(1, 4);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) send_sample(18'($urandom_range(0, sb.thr > 0 ? int'(sb.thr) - 1 : 0)));
      end
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, threshold edges, then a clean pulse train
    send_sample(18'd0);
    send_sample(FINGER_THR_RST - 18'd1);
    send_sample(FINGER_THR_RST);
    send_sample(18'h3FFFF);
    send_wave(100000, 20000, 16, 20, 0, 1'b0);

    // register extremes: everything accepted, nothing accepted, fast beats,
    // zero sample period, empty interval window
    run_phase(0, 0, 0, 65535, 255, 35, 1'b1);
    run_phase(IR_MAX, IR_MAX, 65535, 0, 1, 35, 1'b0);
    run_phase(0, 0, 0, 65535, 1, 35, 1'b1);
    run_phase(40000, 100, 0, 0, 0, 35, 1'b0);
    run_phase(30000, 50, 500, 501, 40, 35, 1'b1);

    // random settings, mostly in the working range
    for (int p = 0; p < 6; p++) begin
      run_phase($urandom_range(0, 1) ? $urandom_range(0, 120000) : $urandom_range(0, IR_MAX),
                $urandom_range(0, 3000), $urandom_range(100, 700),
                $urandom_range(700, 3000), $urandom_range(1, 80), 40, p[0]);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/hbd_pkg.sv
sv/hbd_front.sv
sv/hbd_queue.sv
sv/hbd_div.sv
sv/hbd_back.sv
sv/heart_beat_bpm_detector_core.sv
bench/heart_beat_bpm_detector_core_tb.sv
